// File: src/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// shared types, queue sizing and round tables for the md5 digest engine
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

    // request as it travels from the front to the back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } item_t;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // chaining word initial values
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [3:0] LAST_OUT = 4'd15;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROUND_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] wide;
        wide = {x, x} << s;
        return wide[63:32];
    endfunction

    // message word used by each round
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] rl;
        logic [3:0] g;
        rl = r[3:0];
        case (r[5:4])
            2'd0:    g = rl;
            2'd1:    g = 4'(rl * 4'd5 + 4'd1);
            2'd2:    g = 4'(rl * 4'd3 + 4'd5);
            default: g = 4'(rl * 4'd7);
        endcase
        return g;
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] phase,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        case (phase)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (d & b) | (~d & c);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// File: src/md5_front.sv
// ----------------------------------------------------------------------------
// md5_front
// takes input requests, drops the ones that carry neither byte nor end mark,
// and holds the rest in a short queue for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module md5_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    data_byte,
    input  wire logic          has_byte,
    input  wire logic          last,
    output md5_pkg::item_t     q_item,
    output logic               q_valid,
    input  wire logic          q_pop
);

    md5_pkg::item_t                q_mem_reg [md5_pkg::Q_DEPTH];
    logic [md5_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [md5_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [md5_pkg::Q_CNT_W-1:0]   count_reg, count_next;
    logic                          push;
    logic                          do_pop;

    assign in_ready = (count_reg != md5_pkg::Q_CNT_W'(md5_pkg::Q_DEPTH));
    // an idle request changes nothing, so it never enters the queue
    assign push     = in_valid && in_ready && (has_byte || last);
    assign q_valid  = (count_reg != '0);
    assign do_pop   = q_pop && q_valid;
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == md5_pkg::Q_PTR_W'(md5_pkg::Q_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == md5_pkg::Q_PTR_W'(md5_pkg::Q_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg].data_byte <= data_byte;
            q_mem_reg[wr_ptr_reg].has_byte  <= has_byte;
            q_mem_reg[wr_ptr_reg].last      <= last;
        end
    end

endmodule

`default_nettype wire

// File: src/md5_back.sv
// ----------------------------------------------------------------------------
// md5_back
// packs bytes into the block, pads the message, runs one md5 round per
// cycle and hands out the digest bytes
// ----------------------------------------------------------------------------
`default_nettype none

module md5_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire md5_pkg::item_t q_item,
    input  wire logic          q_valid,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         digest_byte,
    output logic               digest_last
);

    typedef enum logic [3:0] {
        ST_ABSORB = 4'b0001,
        ST_ROUND  = 4'b0010,
        ST_PAD    = 4'b0100,
        ST_OUT    = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [5:0]    fill_reg, fill_next;
    logic [63:0]   len_reg, len_next;
    logic [5:0]    round_reg, round_next;
    logic          pad_reg, pad_next;
    logic          mark_reg, mark_next;
    logic          tail_reg, tail_next;
    logic [3:0]    out_idx_reg, out_idx_next;
    logic [31:0]   chain_reg [4];
    logic [31:0]   chain_next [4];
    logic [31:0]   a_reg, b_reg, c_reg, d_reg;
    logic [31:0]   a_next, b_next, c_next, d_next;
    logic [31:0]   block_reg [16];

    logic          put_en;
    logic [7:0]    put_byte;
    logic [7:0]    pad_byte;
    logic          tail_now;
    logic          full;
    logic [31:0]   rot_sum;
    logic [31:0]   b_round;

    assign q_pop = (state_reg == ST_ABSORB) && q_valid;

    // length bytes go out while the fill sits at 56..63
    assign tail_now = mark_reg && (tail_reg || (fill_reg == md5_pkg::LEN_POS));
    assign pad_byte = tail_now ? len_reg[{fill_reg[2:0], 3'b000} +: 8]
                    : (mark_reg ? 8'h00 : md5_pkg::PAD_MARK);
    assign put_en   = (q_pop && q_item.has_byte) || (state_reg == ST_PAD);
    assign put_byte = q_pop ? q_item.data_byte : pad_byte;
    assign full     = put_en && (fill_reg == md5_pkg::LAST_POS);

    assign rot_sum = a_reg
                   + md5_pkg::round_f(round_reg[5:4], b_reg, c_reg, d_reg)
                   + md5_pkg::ROUND_K[round_reg]
                   + block_reg[md5_pkg::msg_index(round_reg)];
    assign b_round = b_reg + md5_pkg::rotl32(rot_sum,
                                             md5_pkg::ROUND_S[{round_reg[5:4], round_reg[1:0]}]);

    assign out_valid   = (state_reg == ST_OUT);
    assign digest_byte = chain_reg[out_idx_reg[3:2]][{out_idx_reg[1:0], 3'b000} +: 8];
    assign digest_last = (out_idx_reg == md5_pkg::LAST_OUT);

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        len_next     = len_reg;
        round_next   = round_reg;
        pad_next     = pad_reg;
        mark_next    = mark_reg;
        tail_next    = tail_reg;
        out_idx_next = out_idx_reg;
        chain_next   = chain_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        d_next       = d_reg;

        if (put_en)
            fill_next = fill_reg + 1'b1;
        if (full)
        begin
            a_next     = chain_reg[0];
            b_next     = chain_reg[1];
            c_next     = chain_reg[2];
            d_next     = chain_reg[3];
            round_next = '0;
        end

        case (state_reg)
            ST_ABSORB:
            begin
                if (q_pop)
                begin
                    if (q_item.has_byte)
                        len_next = len_reg + 64'd8;
                    if (full)
                    begin
                        state_next = ST_ROUND;
                        pad_next   = q_item.last;
                    end
                    else if (q_item.last)
                    begin
                        state_next = ST_PAD;
                        pad_next   = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                mark_next = 1'b1;
                if (tail_now)
                    tail_next = 1'b1;
                if (full)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                a_next     = d_reg;
                b_next     = b_round;
                c_next     = b_reg;
                d_next     = c_reg;
                round_next = round_reg + 1'b1;
                if (round_reg == md5_pkg::LAST_POS)
                begin
                    chain_next[0] = chain_reg[0] + d_reg;
                    chain_next[1] = chain_reg[1] + b_round;
                    chain_next[2] = chain_reg[2] + b_reg;
                    chain_next[3] = chain_reg[3] + c_reg;
                    if (tail_reg)
                        state_next = ST_OUT;
                    else if (pad_reg)
                        state_next = ST_PAD;
                    else
                        state_next = ST_ABSORB;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    out_idx_next = out_idx_reg + 1'b1;
                    if (out_idx_reg == md5_pkg::LAST_OUT)
                    begin
                        // digest delivered: start the next message
                        chain_next[0] = md5_pkg::IV_A;
                        chain_next[1] = md5_pkg::IV_B;
                        chain_next[2] = md5_pkg::IV_C;
                        chain_next[3] = md5_pkg::IV_D;
                        len_next      = '0;
                        fill_next     = '0;
                        pad_next      = 1'b0;
                        mark_next     = 1'b0;
                        tail_next     = 1'b0;
                        state_next    = ST_ABSORB;
                    end
                end
            end
            default:
            begin
                state_next = ST_ABSORB;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_ABSORB;
            fill_reg     <= '0;
            len_reg      <= '0;
            round_reg    <= '0;
            pad_reg      <= 1'b0;
            mark_reg     <= 1'b0;
            tail_reg     <= 1'b0;
            out_idx_reg  <= '0;
            chain_reg[0] <= md5_pkg::IV_A;
            chain_reg[1] <= md5_pkg::IV_B;
            chain_reg[2] <= md5_pkg::IV_C;
            chain_reg[3] <= md5_pkg::IV_D;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            len_reg      <= len_next;
            round_reg    <= round_next;
            pad_reg      <= pad_next;
            mark_reg     <= mark_next;
            tail_reg     <= tail_next;
            out_idx_reg  <= out_idx_next;
            chain_reg    <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        if (put_en)
        begin
            // first byte of a word clears the upper lanes
            if (fill_reg[1:0] == 2'b00)
                block_reg[fill_reg[5:2]] <= {24'h000000, put_byte};
            else
                block_reg[fill_reg[5:2]][{fill_reg[1:0], 3'b000} +: 8] <= put_byte;
        end
    end

endmodule

`default_nettype wire

// File: src/md5_digest_engine.sv
// ----------------------------------------------------------------------------
// md5_digest_engine
// streaming md5: message bytes in, 16 digest bytes out per message
// ----------------------------------------------------------------------------
// a byte request is absorbed when the back end pops it; every 64th byte adds a block of
// rounds, one round per cycle through the single round adder and rotator
// an end request adds the padding bytes, the rounds of one or two blocks and
// the 16 digest bytes of output before the next message is absorbed
// the 4-entry request queue keeps taking requests while the back end works, until it is full
// reset clears the queue and control and loads the initial chaining words
`default_nettype none

module md5_digest_engine (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       has_byte,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      digest_byte,
    output logic            digest_last
);

    md5_pkg::item_t q_item;
    logic           q_valid;
    logic           q_pop;

    md5_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .last      (last),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_pop     (q_pop)
    );

    md5_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_item      (q_item),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_byte (digest_byte),
        .digest_last (digest_last)
    );

    // no request is absorbed while a digest is being handed out
    a_no_pop_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !out_valid)
        else $error("request taken while digest pending");

    // back end pops only what the queue holds
    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // after the final digest byte the engine returns to absorbing
    a_out_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && digest_last) |=> !out_valid)
        else $error("digest output did not end");

endmodule

`default_nettype wire

// File: tb/sv/md5_digest_check_pkg.sv
// ----------------------------------------------------------------------------
// md5_digest_check_pkg
// message tracker for the md5 digest engine bench: absorbs accepted requests
// into its own md5 state and holds the digest bytes each message must produce
// ----------------------------------------------------------------------------
package md5_digest_check_pkg;

    import md5_pkg::item_t;

    typedef struct {
        logic [7:0] digest_byte;
        logic       digest_last;
    } digest_out_t;

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotate amounts, four per group of sixteen rounds
    localparam int ROT_AMT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    localparam int PAD_STOP = 56;

    class md5_digest_tracker;

        logic [31:0] chain [4];
        logic [31:0] words [16];
        int          fill;
        logic [63:0] msg_bits;
        digest_out_t digest_due [$];
        int          mismatches;
        int          out_index;

        function new();
            mismatches = 0;
            out_index  = 0;
            start_message();
        endfunction

        function void start_message();
            chain[0] = 32'h67452301;
            chain[1] = 32'hefcdab89;
            chain[2] = 32'h98badcfe;
            chain[3] = 32'h10325476;
            foreach (words[i])
                words[i] = '0;
            fill     = 0;
            msg_bits = '0;
        endfunction

        function logic [31:0] rotl(logic [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void compress();
            logic [31:0] a, b, c, d, f, t;
            int g;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int r = 0; r < 64; r++)
            begin
                case (r / 16)
                    0:
                    begin
                        f = (b & c) | (~b & d);
                        g = r;
                    end
                    1:
                    begin
                        f = (d & b) | (~d & c);
                        g = (5 * r + 1) % 16;
                    end
                    2:
                    begin
                        f = b ^ c ^ d;
                        g = (3 * r + 5) % 16;
                    end
                    default:
                    begin
                        f = c ^ (b | ~d);
                        g = (7 * r) % 16;
                    end
                endcase
                t = d;
                d = c;
                c = b;
                b = b + rotl(a + f + SINE_K[r] + words[g], ROT_AMT[(r / 16) * 4 + r % 4]);
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        // little-endian packing, block runs once the 64th byte lands
        function void absorb_byte(logic [7:0] v);
            int w;
            w = fill / 4;
            if (fill % 4 == 0)
                words[w] = '0;
            words[w][8 * (fill % 4) +: 8] = v;
            if (fill == 63)
            begin
                compress();
                fill = 0;
            end
            else
                fill = fill + 1;
        endfunction

        function void take_request(item_t req);
            logic [63:0] len;
            digest_out_t d;
            if (req.has_byte)
            begin
                absorb_byte(req.data_byte);
                msg_bits = msg_bits + 64'd8;
            end
            if (!req.last)
                return;
            len = msg_bits;
            absorb_byte(8'h80);
            while (fill != PAD_STOP)
                absorb_byte(8'h00);
            for (int k = 0; k < 8; k++)
                absorb_byte(len[8 * k +: 8]);
            for (int k = 0; k < 16; k++)
            begin
                d.digest_byte = chain[k / 4][8 * (k % 4) +: 8];
                d.digest_last = (k == 15);
                digest_due.push_back(d);
            end
            start_message();
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void check_digest_byte(logic [7:0] got_byte, logic got_last);
            digest_out_t d;
            if (digest_due.size() == 0)
            begin
                note_mismatch($sformatf("digest byte %02h last %b with none pending",
                                        got_byte, got_last));
                return;
            end
            d = digest_due.pop_front();
            if (got_byte !== d.digest_byte)
                note_mismatch($sformatf("byte %0d: digest_byte expected %02h got %02h",
                                        out_index, d.digest_byte, got_byte));
            if (got_last !== d.digest_last)
                note_mismatch($sformatf("byte %0d: digest_last expected %b got %b",
                                        out_index, d.digest_last, got_last));
            out_index++;
        endfunction

        function int pending();
            return digest_due.size();
        endfunction

    endclass

endpackage

// File: tb/sv/md5_digest_engine_tb.sv
// ----------------------------------------------------------------------------
// md5_digest_engine_tb
// streams directed and random messages into the md5 engine with random
// stalls on both sides, predicts each digest and checks every output byte
// ----------------------------------------------------------------------------
module md5_digest_engine_tb;

    import md5_pkg::*;
    import md5_digest_check_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 250;
    localparam int RANDOM_ITEMS = 180;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] digest_byte;
    logic       digest_last;

    md5_digest_tracker tracker;
    int   cycle_count = 0;
    int   send_burst = 0;
    int   recv_burst = 0;
    logic hold_armed = 1'b0;

    md5_digest_engine uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .has_byte    (has_byte),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_byte (digest_byte),
        .digest_last (digest_last)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("md5_digest_engine_tb failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one or a burst with none
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input logic [7:0] b, input logic hb, input logic lst);
        int gap;
        gap = pick_gap(send_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        has_byte  <= hb;
        last      <= lst;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
    endtask

    always @(posedge clk)
    begin : request_monitor
        item_t req;
        if (in_valid === 1'b1 && in_ready === 1'b1)
        begin
            req.data_byte = data_byte;
            req.has_byte  = has_byte;
            req.last      = last;
            tracker.take_request(req);
        end
    end

    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready === 1'b1)
            tracker.check_digest_byte(digest_byte, digest_last);
    end

    initial
    begin : receiver
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            // one long hold so the request queue backs up
            if (hold_armed && out_valid === 1'b1)
            begin
                hold_armed = 1'b0;
                gap = HOLD_CYCLES;
            end
            else
                gap = pick_gap(recv_burst);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int msg_len;
        int sent;
        logic end_on_byte;
        tracker   = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        has_byte  = 1'b0;
        last      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty message, then an idle request between messages
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hff, 1'b0, 1'b0);
        // single byte extremes carried on the ending request
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'hff, 1'b1, 1'b1);
        // "abc" with an idle request inside and a bare end
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h5a, 1'b0, 1'b0);
        send_request(8'h63, 1'b1, 1'b0);
        send_request(8'ha5, 1'b0, 1'b1);
        send_request(8'h80, 1'b1, 1'b0);
        send_request(8'h7f, 1'b1, 1'b1);

        hold_armed = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // lengths around one and two block boundaries now and then
            case ($urandom_range(0, 9))
                7, 8:    msg_len = $urandom_range(52, 72);
                9:       msg_len = $urandom_range(112, 136);
                default: msg_len = $urandom_range(0, 12);
            endcase
            // keep the total close to the planned count
            if (msg_len > RANDOM_ITEMS - sent)
                msg_len = RANDOM_ITEMS - sent;
            end_on_byte = 1'($urandom_range(0, 1));
            for (int i = 0; i < msg_len; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_request(8'($urandom), 1'b0, 1'b0);
                send_request(8'($urandom), 1'b1, end_on_byte && (i == msg_len - 1));
                sent++;
            end
            if (msg_len == 0 || !end_on_byte)
            begin
                send_request(8'($urandom), 1'b0, 1'b1);
                sent++;
            end
        end
        in_valid <= 1'b0;
        // let the monitor take the final request before looking at the queue
        @(posedge clk);

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("md5_digest_engine_tb passed");
        else
            $display("md5_digest_engine_tb failed");
        $finish;
    end

endmodule

// File: filelist.f
src/md5_pkg.sv
src/md5_front.sv
src/md5_back.sv
src/md5_digest_engine.sv
tb/sv/md5_digest_check_pkg.sv
tb/sv/md5_digest_engine_tb.sv
